### hdl/olst_pkg.sv
// olst_pkg: shared widths, operation codes and status codes for the ordered list store
// no dependencies; used by the interfaces, the controller, the datapath and the top level
package olst_pkg;

    // fixed field widths
    localparam int OP_W     = 2;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // default list capacity
    localparam int DEF_CAPACITY = 16;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

    // command from controller to datapath
    typedef struct packed {
        logic exec;
    } olst_cmd_t;

endpackage

### hdl/olst_req_if.sv
// olst_req_if: request channel carrying one list operation per transfer
// depends on olst_pkg for field widths
interface olst_req_if;
    logic                            valid;
    logic                            ready;
    logic [olst_pkg::OP_W-1:0]       opcode;
    logic [olst_pkg::POS_W-1:0]      position;
    logic signed [olst_pkg::DATA_W-1:0] value;

    modport source (output valid, output opcode, output position, output value, input ready);
    modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

### hdl/olst_rsp_if.sv
// olst_rsp_if: response channel carrying one result per transfer
// depends on olst_pkg for field widths
interface olst_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [olst_pkg::STATUS_W-1:0]      status;
    logic signed [olst_pkg::DATA_W-1:0] read_value;
    logic [olst_pkg::COUNT_W-1:0]       count;

    modport source (output valid, output status, output read_value, output count, input ready);
    modport sink   (input valid, input status, input read_value, input count, output ready);
endinterface

### hdl/olst_ctrl.sv
// olst_ctrl: handshake controller; issues one execute command per accepted request
// depends on olst_pkg for the command type
module olst_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output olst_pkg::olst_cmd_t cmd
);
    import olst_pkg::*;

    typedef enum logic {
        S_EMPTY,
        S_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // a new request is taken when the result slot is empty or draining
    assign in_ready  = (state_reg == S_EMPTY) || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = (state_reg == S_HOLD);
    assign cmd.exec  = accept;

    // next state
    always_comb
    begin
        unique case (state_reg)
            S_EMPTY: state_next = accept ? S_HOLD : S_EMPTY;
            S_HOLD:  state_next = (accept || !out_ready) ? S_HOLD : S_EMPTY;
            default: state_next = S_EMPTY;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

### hdl/olst_dp.sv
// olst_dp: list cells with parallel neighbor shift, entry count and result register
// depends on olst_pkg for codes, widths and the command type
module olst_dp #(
    parameter int CAPACITY = olst_pkg::DEF_CAPACITY
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  olst_pkg::olst_cmd_t               cmd,
    input  logic [olst_pkg::OP_W-1:0]         opcode,
    input  logic [olst_pkg::POS_W-1:0]        position,
    input  logic signed [olst_pkg::DATA_W-1:0] value,
    output logic [olst_pkg::STATUS_W-1:0]     status,
    output logic signed [olst_pkg::DATA_W-1:0] read_value,
    output logic [olst_pkg::COUNT_W-1:0]      count
);
    import olst_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int CMP_W2 = (CMP_W > COUNT_W) ? CMP_W : COUNT_W;
    localparam int RD_N   = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

    logic [DATA_W-1:0] cells_reg [CAPACITY];
    logic [DATA_W-1:0] cells_next [CAPACITY];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [DATA_W-1:0] rdata_reg;
    logic [DATA_W-1:0] rdata_next;

    logic [CMP_W-1:0]  pos_x;
    logic [CMP_W-1:0]  cnt_x;
    logic [CMP_W-1:0]  ins_pos;
    logic              is_full;
    logic              pos_present;
    logic              do_insert;
    logic              do_erase;
    logic [DATA_W-1:0] cell_at_pos;

    // operand decode
    assign pos_x       = CMP_W'(position);
    assign cnt_x       = CMP_W'(count_reg);
    assign is_full     = (count_reg == CNT_W'(CAPACITY));
    assign pos_present = (pos_x < cnt_x);
    assign ins_pos     = (pos_x > cnt_x) ? cnt_x : pos_x;
    assign do_insert   = cmd.exec && (opcode == OP_INSERT) && !is_full;
    assign do_erase    = cmd.exec && (opcode == OP_ERASE) && pos_present;

    // read select over the addressable cells
    always_comb
    begin
        cell_at_pos = '0;
        for (int k = 0; k < RD_N; k++)
        begin
            if (position == POS_W'(k))
            begin
                cell_at_pos = cells_reg[k];
            end
        end
    end

    // per-cell next value: shift up on insert, shift down on erase
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_W-1:0] from_below;
        logic [DATA_W-1:0] from_above;

        if (g == 0)
        begin : g_lo
            assign from_below = cells_reg[g];
        end
        else
        begin : g_mid_lo
            assign from_below = cells_reg[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_hi
            assign from_above = cells_reg[g];
        end
        else
        begin : g_mid_hi
            assign from_above = cells_reg[g+1];
        end

        always_comb
        begin
            cells_next[g] = cells_reg[g];
            if (do_insert)
            begin
                if (CMP_W2'(g) == CMP_W2'(ins_pos))
                begin
                    cells_next[g] = value;
                end
                else if (CMP_W2'(g) > CMP_W2'(ins_pos))
                begin
                    cells_next[g] = from_below;
                end
            end
            else if (do_erase)
            begin
                if (CMP_W2'(g) >= CMP_W2'(pos_x))
                begin
                    cells_next[g] = from_above;
                end
            end
        end
    end

    // count and result
    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_DONE;
        rdata_next  = '0;
        unique case (opcode)
            OP_INSERT:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_ERASE:
            begin
                if (!pos_present)
                begin
                    status_next = ST_ABSENT;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_READ:
            begin
                if (!pos_present)
                begin
                    status_next = ST_ABSENT;
                end
                else
                begin
                    rdata_next = cell_at_pos;
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    // cell array
    always_ff @(posedge clk)
    begin
        if (do_insert || do_erase)
        begin
            cells_reg <= cells_next;
        end
    end

    // entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg <= status_next;
            rdata_reg  <= rdata_next;
        end
    end

    assign status     = status_reg;
    assign read_value = rdata_reg;
    assign count      = COUNT_W'(CMP_W2'(count_reg));
endmodule

### hdl/ordered_list_store.sv
// ordered_list_store: every operation executes in the cycle of its request transfer;
// the result is valid in the cycle after; while rsp.ready is high, throughput is one
// operation per cycle, since a new request is taken while the held result is being
// transferred out. the per-cell neighbor shift does insert and erase in that cycle.
// asynchronous active-low reset empties the list; cell contents are not cleared.
module ordered_list_store #(
    parameter int CAPACITY = olst_pkg::DEF_CAPACITY
) (
    input  logic       clk,
    input  logic       rst_n,
    olst_req_if.sink   req,
    olst_rsp_if.source rsp
);
    import olst_pkg::*;

    olst_cmd_t cmd;

    // handshake controller
    olst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // list datapath
    olst_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .opcode     (req.opcode),
        .position   (req.position),
        .value      (req.value),
        .status     (rsp.status),
        .read_value (rsp.read_value),
        .count      (rsp.count)
    );
endmodule

### tb/sv/list_result_checker.sv
// list_result_checker: watches the request and response channels of the ordered list store,
// keeps its own copy of the list, and compares every response with the predicted one
// depends on olst_pkg, olst_req_if and olst_rsp_if
module list_result_checker #(
    parameter int CAPACITY = olst_pkg::DEF_CAPACITY
) (
    input  logic clk,
    input  logic rst_n,
    olst_req_if  req,
    olst_rsp_if  rsp,
    output int   errors,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import olst_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] read_value;
        logic [COUNT_W-1:0]       count;
    } list_result_t;

    // shadow copy of the list
    logic signed [DATA_W-1:0] cells [CAPACITY];
    int                       fill_count = 0;

    list_result_t result_q [$];
    int           mismatch_total = 0;
    int           result_index = 0;

    // one line per mismatch
    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch in %s at response %0d: got %0d, want %0d",
                 what, result_index, got, want);
        mismatch_total++;
    endtask

    // apply one operation to the shadow list and return its response
    function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic signed [DATA_W-1:0] val);
        list_result_t res;
        int           slot;
        res.status     = ST_DONE;
        res.read_value = '0;
        slot           = int'(pos);
        case (op)
            OP_INSERT:
            begin
                if (fill_count >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    // a position past the end appends
                    if (slot > fill_count)
                        slot = fill_count;
                    for (int i = fill_count; i > slot; i--)
                        cells[i] = cells[i-1];
                    cells[slot] = val;
                    fill_count++;
                end
            end
            OP_ERASE:
            begin
                if (slot >= fill_count)
                    res.status = ST_ABSENT;
                else
                begin
                    for (int i = slot; i + 1 < fill_count; i++)
                        cells[i] = cells[i+1];
                    fill_count--;
                end
            end
            OP_READ:
            begin
                if (slot >= fill_count)
                    res.status = ST_ABSENT;
                else
                    res.read_value = cells[slot];
            end
            default:
            begin
                // unused opcode leaves the list alone
            end
        endcase
        res.count = fill_count[COUNT_W-1:0];
        return res;
    endfunction

    // compare responses first, then predict the request taken at the same edge
    always @(posedge clk or negedge rst_n)
    begin : track
        list_result_t want;
        if (!rst_n)
        begin
            fill_count = 0;
            result_q.delete();
            pending <= 0;
            errors  <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (result_q.size() == 0)
                    report_mismatch("unexpected response", rsp.status, -1);
                else
                begin
                    want = result_q.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", rsp.status, want.status);
                    if (rsp.read_value !== want.read_value)
                        report_mismatch("read_value", rsp.read_value, want.read_value);
                    if (rsp.count !== want.count)
                        report_mismatch("count", rsp.count, want.count);
                end
                result_index++;
            end
            if (req.valid && req.ready)
                result_q.push_back(apply_list_op(req.opcode, req.position, req.value));
            pending <= result_q.size();
            errors  <= mismatch_total;
        end
    end

endmodule

### tb/sv/tb_ordered_list_store.sv
// tb_ordered_list_store: drives directed and random list operations into the ordered list
// store with random idling on both channels; list_result_checker predicts and compares
// depends on olst_pkg, olst_req_if, olst_rsp_if, ordered_list_store and list_result_checker
module tb_ordered_list_store;
    timeunit 1ns;
    timeprecision 1ps;

    import olst_pkg::*;

    localparam int              LIST_CAP    = DEF_CAPACITY;
    localparam int              RANDOM_OPS  = 1150;
    localparam int              STALL_LIMIT = 2000;
    localparam logic [OP_W-1:0] OP_NONE     = 2'd3;

    typedef struct {
        logic [OP_W-1:0]          opcode;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } list_op_t;

    typedef enum {RUN_FILL, RUN_DRAIN, RUN_MIXED} run_kind_t;

    logic clk;
    logic rst_n;
    int   mismatch_count;
    int   outstanding;
    int   stall_cycles;

    olst_req_if req_bus ();
    olst_rsp_if rsp_bus ();

    ordered_list_store #(.CAPACITY(LIST_CAP)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    list_result_checker #(.CAPACITY(LIST_CAP)) result_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_bus),
        .rsp     (rsp_bus),
        .errors  (mismatch_count),
        .pending (outstanding)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic list_op_t make_op(input logic [OP_W-1:0] op, input int pos,
                                         input logic signed [DATA_W-1:0] val);
        list_op_t item;
        item.opcode   = op;
        item.position = pos[POS_W-1:0];
        item.value    = val;
        return item;
    endfunction

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
        else
            stall_cycles <= 0;
    end

    initial
    begin : stimulus
        list_op_t  op_list [$];
        list_op_t  item;
        run_kind_t run_kind;
        int        run_len;
        int        pick;
        int        next_item;
        int        send_idle;
        int        recv_idle;
        int        total;

        req_bus.valid    <= 1'b0;
        req_bus.opcode   <= OP_INSERT;
        req_bus.position <= '0;
        req_bus.value    <= '0;
        rsp_bus.ready    <= 1'b0;
        rst_n            <= 1'b0;

        // empty list: read, erase and the unused opcode
        op_list.push_back(make_op(OP_READ, 0, 0));
        op_list.push_back(make_op(OP_ERASE, 0, 0));
        op_list.push_back(make_op(OP_NONE, 31, -1));

        // fill to capacity with front, middle and past-the-end inserts
        for (int i = 0; i < LIST_CAP; i++)
        begin
            pick = (i == 1) ? 31 : ((i % 4) == 3) ? 0 : (i * 5) % 17;
            case (i)
                0:       op_list.push_back(make_op(OP_INSERT, pick, 32'sh8000_0000));
                1:       op_list.push_back(make_op(OP_INSERT, pick, 32'sh7fff_ffff));
                2:       op_list.push_back(make_op(OP_INSERT, pick, 0));
                3:       op_list.push_back(make_op(OP_INSERT, pick, -1));
                default: op_list.push_back(make_op(OP_INSERT, pick, $urandom));
            endcase
        end

        // full list: refused insert, last and absent reads, absent, back and front erases
        op_list.push_back(make_op(OP_INSERT, 4, 32'h1234_5678));
        op_list.push_back(make_op(OP_READ, LIST_CAP - 1, 0));
        op_list.push_back(make_op(OP_READ, LIST_CAP, 0));
        op_list.push_back(make_op(OP_ERASE, LIST_CAP, 0));
        op_list.push_back(make_op(OP_ERASE, LIST_CAP - 1, 0));
        op_list.push_back(make_op(OP_ERASE, 0, 0));

        // random runs biased toward filling, draining or a mix
        total = op_list.size() + RANDOM_OPS;
        while (op_list.size() < total)
        begin
            pick     = $urandom_range(2);
            run_kind = (pick == 0) ? RUN_FILL : (pick == 1) ? RUN_DRAIN : RUN_MIXED;
            run_len  = $urandom_range(10, 40);
            for (int k = 0; k < run_len; k++)
            begin
                pick = $urandom_range(99);
                case (run_kind)
                    RUN_FILL:  item.opcode = (pick < 75) ? OP_INSERT : (pick < 85) ? OP_ERASE :
                                             (pick < 97) ? OP_READ : OP_NONE;
                    RUN_DRAIN: item.opcode = (pick < 10) ? OP_INSERT : (pick < 80) ? OP_ERASE :
                                             (pick < 97) ? OP_READ : OP_NONE;
                    default:   item.opcode = (pick < 35) ? OP_INSERT : (pick < 65) ? OP_ERASE :
                                             (pick < 97) ? OP_READ : OP_NONE;
                endcase
                pick = $urandom_range(99);
                if (pick < 10)
                    item.position = POS_W'($urandom_range(31));
                else if (pick < 50)
                    item.position = POS_W'($urandom_range(7));
                else
                    item.position = POS_W'($urandom_range(LIST_CAP));
                pick = $urandom_range(99);
                case (pick)
                    0:       item.value = 32'sh8000_0000;
                    1:       item.value = 32'sh7fff_ffff;
                    2:       item.value = 0;
                    3:       item.value = -1;
                    default: item.value = $urandom;
                endcase
                op_list.push_back(item);
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // send every operation; idling pattern changes by thirds of the run
        total     = op_list.size();
        next_item = 0;
        while (next_item < total)
        begin
            @(posedge clk);
            if (req_bus.valid && req_bus.ready)
                next_item++;
            if (next_item < total / 3)
            begin
                send_idle = 13;
                recv_idle = 59;
            end
            else if (next_item < (2 * total) / 3)
            begin
                send_idle = 59;
                recv_idle = 13;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            rsp_bus.ready <= !($urandom_range(99) < recv_idle);
            // a held transfer stays put until it is taken
            if (!req_bus.valid || req_bus.ready)
            begin
                if (next_item < total && !($urandom_range(99) < send_idle))
                begin
                    req_bus.valid    <= 1'b1;
                    req_bus.opcode   <= op_list[next_item].opcode;
                    req_bus.position <= op_list[next_item].position;
                    req_bus.value    <= op_list[next_item].value;
                end
                else
                    req_bus.valid <= 1'b0;
            end
        end

        // drain the remaining responses, then allow for the response latency
        do
        begin
            @(posedge clk);
            rsp_bus.ready <= 1'b1;
        end
        while (outstanding != 0);
        repeat (4) @(posedge clk);

        if (mismatch_count == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
hdl/olst_pkg.sv
hdl/olst_req_if.sv
hdl/olst_rsp_if.sv
hdl/olst_ctrl.sv
hdl/olst_dp.sv
hdl/ordered_list_store.sv
tb/sv/list_result_checker.sv
tb/sv/tb_ordered_list_store.sv
